@@ rtl/mtk_pkg.sv @@
// Package for the Morse text keyer sequencer: word types, codes, states and the code table.
package mtk_pkg;

    // Code table geometry and element limit.
    localparam int CODE_TABLE_DEPTH = 128;
    localparam int CODE_IDX_W       = $clog2(CODE_TABLE_DEPTH);
    localparam int MAX_ELEMENTS     = 6;
    localparam int ELEM_IDX_W       = $clog2(MAX_ELEMENTS);
    localparam int COUNT_W          = 3;
    localparam int CODE_W           = COUNT_W + MAX_ELEMENTS;

    // Field and register widths.
    localparam int LEN_W   = 19;
    localparam int ALU_W   = LEN_W + 1;
    localparam int DOT_W   = 16;
    localparam int RAMP_W  = 12;
    localparam int HANG_W  = 8;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Input commands.
    localparam logic [1:0] CMD_CHAR = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    // Segment kinds.
    localparam logic [2:0] SEG_SILENCE   = 3'd0;
    localparam logic [2:0] SEG_RAMP_UP   = 3'd1;
    localparam logic [2:0] SEG_STEADY    = 3'd2;
    localparam logic [2:0] SEG_RAMP_DOWN = 3'd3;
    localparam logic [2:0] SEG_END       = 3'd4;

    // Transmit switch requests.
    localparam logic [1:0] PTT_NONE = 2'd0;
    localparam logic [1:0] PTT_ON   = 2'd1;
    localparam logic [1:0] PTT_OFF  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_DOT_SPACE = 2'd0;
    localparam logic [1:0] REG_RISE      = 2'd1;
    localparam logic [1:0] REG_FALL      = 2'd2;
    localparam logic [1:0] REG_HANG      = 2'd3;

    // Input word.
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] character;
    } mtk_in_t;

    // Result word.
    typedef struct packed {
        logic [2:0]       segment_kind;
        logic [LEN_W-1:0] segment_length;
        logic [1:0]       ptt_request;
        logic             last;
    } mtk_out_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CALC,
        ST_PTT_ON,
        ST_RISE,
        ST_STEADY,
        ST_FALL,
        ST_GAP,
        ST_CHAR_END,
        ST_SINGLE
    } mtk_state_t;

    // Length computation steps of the shared adder.
    typedef enum logic [2:0] {
        STEP_RAMPS,
        STEP_THREE_D,
        STEP_DOT,
        STEP_DASH,
        STEP_WORD
    } mtk_step_t;

    // What an accepted word turns into.
    typedef enum logic [2:0] {
        ITEM_NONE,
        ITEM_MAPPED,
        ITEM_UNMAPPED,
        ITEM_RELEASE,
        ITEM_END
    } mtk_item_t;

    // Morse code table: element count in the top bits, dash flags below
    // with the first element in bit 0. A zero count means unmapped.
    function automatic logic [CODE_W-1:0] code_lookup(input logic [CODE_IDX_W-1:0] idx);
        logic [CODE_W-1:0] code;
        code = '0;
        unique case (idx)
            CODE_IDX_W'(33):  code = {3'd5, 6'h08};
            CODE_IDX_W'(37):  code = {3'd5, 6'h02};
            CODE_IDX_W'(40):  code = {3'd5, 6'h0D};
            CODE_IDX_W'(42):  code = {3'd6, 6'h28};
            CODE_IDX_W'(43):  code = {3'd5, 6'h0A};
            CODE_IDX_W'(44):  code = {3'd6, 6'h33};
            CODE_IDX_W'(45):  code = {3'd6, 6'h21};
            CODE_IDX_W'(46):  code = {3'd6, 6'h2A};
            CODE_IDX_W'(47):  code = {3'd5, 6'h09};
            CODE_IDX_W'(48):  code = {3'd5, 6'h1F};
            CODE_IDX_W'(49):  code = {3'd5, 6'h1E};
            CODE_IDX_W'(50):  code = {3'd5, 6'h1C};
            CODE_IDX_W'(51):  code = {3'd5, 6'h18};
            CODE_IDX_W'(52):  code = {3'd5, 6'h10};
            CODE_IDX_W'(53):  code = {3'd5, 6'h00};
            CODE_IDX_W'(54):  code = {3'd5, 6'h01};
            CODE_IDX_W'(55):  code = {3'd5, 6'h03};
            CODE_IDX_W'(56):  code = {3'd5, 6'h07};
            CODE_IDX_W'(57):  code = {3'd5, 6'h0F};
            CODE_IDX_W'(61):  code = {3'd5, 6'h11};
            CODE_IDX_W'(63):  code = {3'd6, 6'h0C};
            CODE_IDX_W'(64):  code = {3'd6, 6'h16};
            CODE_IDX_W'(65), CODE_IDX_W'(97):  code = {3'd2, 6'h02};
            CODE_IDX_W'(66), CODE_IDX_W'(98):  code = {3'd4, 6'h01};
            CODE_IDX_W'(67), CODE_IDX_W'(99):  code = {3'd4, 6'h05};
            CODE_IDX_W'(68), CODE_IDX_W'(100): code = {3'd3, 6'h01};
            CODE_IDX_W'(69), CODE_IDX_W'(101): code = {3'd1, 6'h00};
            CODE_IDX_W'(70), CODE_IDX_W'(102): code = {3'd4, 6'h04};
            CODE_IDX_W'(71), CODE_IDX_W'(103): code = {3'd3, 6'h03};
            CODE_IDX_W'(72), CODE_IDX_W'(104): code = {3'd4, 6'h00};
            CODE_IDX_W'(73), CODE_IDX_W'(105): code = {3'd2, 6'h00};
            CODE_IDX_W'(74), CODE_IDX_W'(106): code = {3'd4, 6'h0E};
            CODE_IDX_W'(75), CODE_IDX_W'(107): code = {3'd3, 6'h05};
            CODE_IDX_W'(76), CODE_IDX_W'(108): code = {3'd4, 6'h02};
            CODE_IDX_W'(77), CODE_IDX_W'(109): code = {3'd2, 6'h03};
            CODE_IDX_W'(78), CODE_IDX_W'(110): code = {3'd2, 6'h01};
            CODE_IDX_W'(79), CODE_IDX_W'(111): code = {3'd3, 6'h07};
            CODE_IDX_W'(80), CODE_IDX_W'(112): code = {3'd4, 6'h06};
            CODE_IDX_W'(81), CODE_IDX_W'(113): code = {3'd4, 6'h0B};
            CODE_IDX_W'(82), CODE_IDX_W'(114): code = {3'd3, 6'h02};
            CODE_IDX_W'(83), CODE_IDX_W'(115): code = {3'd3, 6'h00};
            CODE_IDX_W'(84), CODE_IDX_W'(116): code = {3'd1, 6'h01};
            CODE_IDX_W'(85), CODE_IDX_W'(117): code = {3'd3, 6'h04};
            CODE_IDX_W'(86), CODE_IDX_W'(118): code = {3'd4, 6'h08};
            CODE_IDX_W'(87), CODE_IDX_W'(119): code = {3'd3, 6'h06};
            CODE_IDX_W'(88), CODE_IDX_W'(120): code = {3'd4, 6'h09};
            CODE_IDX_W'(89), CODE_IDX_W'(121): code = {3'd4, 6'h0D};
            CODE_IDX_W'(90), CODE_IDX_W'(122): code = {3'd4, 6'h03};
            default: code = '0;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/morse_text_keyer_sequencer.sv @@
// Top level of the Morse text keyer sequencer: APB registers, sequencer and result register.
//
// Usage: each input word (s_valid/s_ready/s_data) is a text character, a 100 ms hang
// tick or an end-of-text marker. Results leave on m_valid/m_ready/m_data as audio
// segments (kind, length in samples, transmit request, last flag), one per cycle
// while the receiver takes them. The APB port holds the dot unit, ramp lengths and
// hang limit; write it only while the block is idle. Reads return the values.
// Timing: a word that causes results first passes through the shared adder,
// which works out the ramp sum, 3d, the dot and dash steady lengths and the word
// space one after another. The first result then goes into the result register
// once it has room, and the rest follow one per cycle while the receiver takes
// them; a word gives up to 26 results. A tick that releases nothing, or command 3,
// gives no result and the block stays idle. s_ready is low while a word is being
// worked on.
// Stalls: the result register holds its word until m_ready; the sequencer waits
// and nothing is lost. s_ready rises as soon as the last result is in the result
// register. Reset (aresetn low, synchronous) restores the register defaults,
// releases transmit, clears the hang count and marks the line as coming from silence.
module morse_text_keyer_sequencer
    import mtk_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  mtk_in_t             s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mtk_out_t            m_data
);

    // Configuration registers.
    logic [DOT_W-1:0]  dot_reg;
    logic [RAMP_W-1:0] rise_reg;
    logic [RAMP_W-1:0] fall_reg;
    logic [HANG_W-1:0] hang_limit_reg;

    // Keyer state.
    logic              transmit_on_reg, transmit_on_next;
    logic [HANG_W-1:0] hang_count_reg, hang_count_next;
    logic              from_silence_reg, from_silence_next;

    // Sequencer control.
    mtk_state_t            state_reg, state_next;
    mtk_step_t             step_reg, step_next;
    mtk_item_t             item_reg, item_next;
    logic [ELEM_IDX_W-1:0] elem_reg, elem_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [MAX_ELEMENTS-1:0] pattern_reg, pattern_next;
    logic                  ptt_need_reg, ptt_need_next;
    logic                  seven_sel_reg, seven_sel_next;

    // Lengths worked out by the shared adder.
    logic [LEN_W-1:0] ramps_reg, ramps_next;
    logic [LEN_W-1:0] three_d_reg, three_d_next;
    logic [LEN_W-1:0] dot_len_reg, dot_len_next;
    logic [LEN_W-1:0] dash_len_reg, dash_len_next;
    logic [LEN_W-1:0] word_len_reg, word_len_next;

    // Result register.
    logic     out_valid_reg, out_valid_next;
    mtk_out_t out_data_reg, out_data_next;

    // Handshake and helper signals.
    logic                  s_fire;
    logic                  load_en;
    logic                  cfg_write;
    logic [CODE_W-1:0]     code;
    logic [COUNT_W-1:0]    code_count;
    logic [COUNT_W-1:0]    code_count_clamped;
    logic [HANG_W-1:0]     hang_inc;
    logic                  release_now;
    logic                  last_elem;
    logic [LEN_W-1:0]      d_ext;

    // Shared add/subtract unit.
    logic [LEN_W-1:0] alu_a;
    logic [LEN_W-1:0] alu_b;
    logic             alu_sub;
    logic [ALU_W:0]   alu_sum;
    logic [LEN_W-1:0] alu_res;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign load_en   = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign d_ext     = LEN_W'(dot_reg);
    assign last_elem = (COUNT_W'(elem_reg) + COUNT_W'(1)) >= count_reg;

    // Register read mux.
    always_comb begin
        unique case (paddr[3:2])
            REG_DOT_SPACE: prdata = PDATA_W'(dot_reg);
            REG_RISE:      prdata = PDATA_W'(rise_reg);
            REG_FALL:      prdata = PDATA_W'(fall_reg);
            REG_HANG:      prdata = PDATA_W'(hang_limit_reg);
            default:       prdata = '0;
        endcase
    end

    // Code lookup and hang tick decision for the word at the input.
    always_comb begin
        code       = code_lookup(s_data.character[CODE_IDX_W-1:0]);
        code_count = code[CODE_W-1:MAX_ELEMENTS];
        if (code_count > COUNT_W'(MAX_ELEMENTS)) begin
            code_count_clamped = COUNT_W'(MAX_ELEMENTS);
        end else begin
            code_count_clamped = code_count;
        end
        if (hang_count_reg == '1) begin
            hang_inc = hang_count_reg;
        end else begin
            hang_inc = hang_count_reg + HANG_W'(1);
        end
        release_now = transmit_on_reg && (hang_inc > hang_limit_reg);
    end

    // Operand selection for the shared adder, one length per step.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (step_reg)
            STEP_RAMPS: begin
                alu_a = LEN_W'(rise_reg);
                alu_b = LEN_W'(fall_reg);
            end
            STEP_THREE_D: begin
                alu_a = d_ext << 1;
                alu_b = d_ext;
            end
            STEP_DOT: begin
                alu_a   = d_ext;
                alu_b   = ramps_reg;
                alu_sub = 1'b1;
            end
            STEP_DASH: begin
                alu_a   = three_d_reg;
                alu_b   = ramps_reg;
                alu_sub = 1'b1;
            end
            STEP_WORD: begin
                if (seven_sel_reg) begin
                    alu_a   = d_ext << 3;
                    alu_b   = d_ext;
                    alu_sub = 1'b1;
                end else begin
                    alu_a = d_ext << 2;
                end
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    // The adder itself; a subtraction that borrows saturates at zero.
    always_comb begin
        alu_sum = {2'b00, alu_a}
                + (alu_sub ? {1'b0, ~{1'b0, alu_b}} : {2'b00, alu_b})
                + (ALU_W + 1)'(alu_sub);
        if (alu_sub && !alu_sum[ALU_W]) begin
            alu_res = '0;
        end else begin
            alu_res = alu_sum[LEN_W-1:0];
        end
    end

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (item_next != ITEM_NONE)) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (step_reg == STEP_WORD) begin
                    if (item_reg == ITEM_MAPPED) begin
                        state_next = ptt_need_reg ? ST_PTT_ON : ST_RISE;
                    end else begin
                        state_next = ST_SINGLE;
                    end
                end
            end
            ST_PTT_ON: if (load_en) state_next = ST_RISE;
            ST_RISE:   if (load_en) state_next = ST_STEADY;
            ST_STEADY: if (load_en) state_next = ST_FALL;
            ST_FALL:   if (load_en) state_next = ST_GAP;
            ST_GAP: begin
                if (load_en) begin
                    state_next = last_elem ? ST_CHAR_END : ST_RISE;
                end
            end
            ST_CHAR_END: if (load_en) state_next = ST_IDLE;
            ST_SINGLE:   if (load_en) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath, keyer state and result register updates.
    always_comb begin
        step_next         = step_reg;
        item_next         = item_reg;
        elem_next         = elem_reg;
        count_next        = count_reg;
        pattern_next      = pattern_reg;
        ptt_need_next     = ptt_need_reg;
        seven_sel_next    = seven_sel_reg;
        ramps_next        = ramps_reg;
        three_d_next      = three_d_reg;
        dot_len_next      = dot_len_reg;
        dash_len_next     = dash_len_reg;
        word_len_next     = word_len_reg;
        transmit_on_next  = transmit_on_reg;
        hang_count_next   = hang_count_reg;
        from_silence_next = from_silence_reg;
        out_valid_next    = out_valid_reg && !m_ready;
        out_data_next     = out_data_reg;

        // Classify the accepted word and update the keyer state at once.
        if (state_reg == ST_IDLE) begin
            item_next = ITEM_NONE;
            if (s_fire) begin
                step_next      = STEP_RAMPS;
                elem_next      = '0;
                count_next     = code_count_clamped;
                pattern_next   = code[MAX_ELEMENTS-1:0];
                ptt_need_next  = !transmit_on_reg;
                seven_sel_next = from_silence_reg;
                unique case (s_data.command)
                    CMD_CHAR: begin
                        if (code_count != '0) begin
                            item_next         = ITEM_MAPPED;
                            hang_count_next   = '0;
                            transmit_on_next  = 1'b1;
                            from_silence_next = 1'b0;
                        end else begin
                            item_next         = ITEM_UNMAPPED;
                            from_silence_next = 1'b1;
                        end
                    end
                    CMD_TICK: begin
                        if (transmit_on_reg) begin
                            if (release_now) begin
                                item_next        = ITEM_RELEASE;
                                transmit_on_next = 1'b0;
                                hang_count_next  = '0;
                            end else begin
                                hang_count_next = hang_inc;
                            end
                        end
                    end
                    CMD_END: item_next = ITEM_END;
                    default: item_next = ITEM_NONE;
                endcase
            end
        end

        // One length per cycle through the shared adder.
        if (state_reg == ST_CALC) begin
            unique case (step_reg)
                STEP_RAMPS: begin
                    ramps_next = alu_res;
                    step_next  = STEP_THREE_D;
                end
                STEP_THREE_D: begin
                    three_d_next = alu_res;
                    step_next    = STEP_DOT;
                end
                STEP_DOT: begin
                    dot_len_next = alu_res;
                    step_next    = STEP_DASH;
                end
                STEP_DASH: begin
                    dash_len_next = alu_res;
                    step_next     = STEP_WORD;
                end
                STEP_WORD: begin
                    word_len_next = alu_res;
                end
                default: step_next = STEP_RAMPS;
            endcase
        end

        // Load the next segment into the result register when it has room.
        if (load_en && (state_reg != ST_IDLE) && (state_reg != ST_CALC)) begin
            out_valid_next               = 1'b1;
            out_data_next.segment_kind   = SEG_SILENCE;
            out_data_next.segment_length = '0;
            out_data_next.ptt_request    = PTT_NONE;
            out_data_next.last           = 1'b0;
            unique case (state_reg)
                ST_PTT_ON: begin
                    out_data_next.segment_length = three_d_reg;
                    out_data_next.ptt_request    = PTT_ON;
                end
                ST_RISE: begin
                    out_data_next.segment_kind   = SEG_RAMP_UP;
                    out_data_next.segment_length = LEN_W'(rise_reg);
                end
                ST_STEADY: begin
                    out_data_next.segment_kind   = SEG_STEADY;
                    out_data_next.segment_length = pattern_reg[elem_reg] ? dash_len_reg
                                                                         : dot_len_reg;
                end
                ST_FALL: begin
                    out_data_next.segment_kind   = SEG_RAMP_DOWN;
                    out_data_next.segment_length = LEN_W'(fall_reg);
                end
                ST_GAP: begin
                    out_data_next.segment_length = d_ext;
                    if (!last_elem) begin
                        elem_next = elem_reg + ELEM_IDX_W'(1);
                    end
                end
                ST_CHAR_END: begin
                    out_data_next.segment_length = d_ext << 1;
                    out_data_next.last           = 1'b1;
                end
                ST_SINGLE: begin
                    out_data_next.last = 1'b1;
                    unique case (item_reg)
                        ITEM_UNMAPPED: out_data_next.segment_length = word_len_reg;
                        ITEM_RELEASE:  out_data_next.ptt_request    = PTT_OFF;
                        ITEM_END:      out_data_next.segment_kind   = SEG_END;
                        default:       out_data_next.segment_kind   = SEG_SILENCE;
                    endcase
                end
                default: out_data_next.last = 1'b0;
            endcase
        end
    end

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            transmit_on_reg  <= 1'b0;
            hang_count_reg   <= '0;
            from_silence_reg <= 1'b1;
            item_reg         <= ITEM_NONE;
            step_reg         <= STEP_RAMPS;
            elem_reg         <= '0;
            dot_reg          <= DOT_W'(3200);
            rise_reg         <= RAMP_W'(240);
            fall_reg         <= RAMP_W'(240);
            hang_limit_reg   <= HANG_W'(15);
        end else begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            transmit_on_reg  <= transmit_on_next;
            hang_count_reg   <= hang_count_next;
            from_silence_reg <= from_silence_next;
            item_reg         <= item_next;
            step_reg         <= step_next;
            elem_reg         <= elem_next;
            if (cfg_write) begin
                unique case (paddr[3:2])
                    REG_DOT_SPACE: dot_reg        <= pwdata[DOT_W-1:0];
                    REG_RISE:      rise_reg       <= pwdata[RAMP_W-1:0];
                    REG_FALL:      fall_reg       <= pwdata[RAMP_W-1:0];
                    REG_HANG:      hang_limit_reg <= pwdata[HANG_W-1:0];
                    default:       dot_reg        <= dot_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        count_reg     <= count_next;
        pattern_reg   <= pattern_next;
        ptt_need_reg  <= ptt_need_next;
        seven_sel_reg <= seven_sel_next;
        ramps_reg     <= ramps_next;
        three_d_reg   <= three_d_next;
        dot_len_reg   <= dot_len_next;
        dash_len_reg  <= dash_len_next;
        word_len_reg  <= word_len_next;
        out_data_reg  <= out_data_next;
    end

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the Morse text keyer sequencer, with a predictor and a segment scoreboard.
module tb;
    import mtk_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 40;

    // Keeps a private copy of the keyer state and registers, predicts the
    // segments of each accepted word and checks the segments that leave.
    class keyer_scoreboard;
        logic [DOT_W-1:0]  dot_unit;
        logic [RAMP_W-1:0] rise_len;
        logic [RAMP_W-1:0] fall_len;
        logic [HANG_W-1:0] hang_lim;
        bit                tx_on;
        int unsigned       hang_ticks;
        bit                after_silence;
        mtk_out_t          segments_due[$];
        int unsigned       failures;
        int unsigned       segments_checked;
        int unsigned       releases;

        function new();
            dot_unit      = 16'd3200;
            rise_len      = 12'd240;
            fall_len      = 12'd240;
            hang_lim      = 8'd15;
            tx_on         = 1'b0;
            hang_ticks    = 0;
            after_silence = 1'b1;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_DOT_SPACE: dot_unit = value[DOT_W-1:0];
                REG_RISE:      rise_len = value[RAMP_W-1:0];
                REG_FALL:      fall_len = value[RAMP_W-1:0];
                REG_HANG:      hang_lim = value[HANG_W-1:0];
                default: ;
            endcase
        endfunction

        // Dots and dashes of a text byte, empty when the byte has no code.
        // Only the low seven bits count; lower case maps onto upper case.
        function string morse_of(logic [7:0] ch);
            logic [7:0] code;
            code = {1'b0, ch[6:0]};
            if (code >= "a" && code <= "z")
                code = code - 8'd32;
            case (code)
                "!": return "...-.";
                "%": return ".-...";
                "(": return "-.--.";
                "*": return "...-.-";
                "+": return ".-.-.";
                ",": return "--..--";
                "-": return "-....-";
                ".": return ".-.-.-";
                "/": return "-..-.";
                "0": return "-----";
                "1": return ".----";
                "2": return "..---";
                "3": return "...--";
                "4": return "....-";
                "5": return ".....";
                "6": return "-....";
                "7": return "--...";
                "8": return "---..";
                "9": return "----.";
                "=": return "-...-";
                "?": return "..--..";
                "@": return ".--.-.";
                "A": return ".-";
                "B": return "-...";
                "C": return "-.-.";
                "D": return "-..";
                "E": return ".";
                "F": return "..-.";
                "G": return "--.";
                "H": return "....";
                "I": return "..";
                "J": return ".---";
                "K": return "-.-";
                "L": return ".-..";
                "M": return "--";
                "N": return "-.";
                "O": return "---";
                "P": return ".--.";
                "Q": return "--.-";
                "R": return ".-.";
                "S": return "...";
                "T": return "-";
                "U": return "..-";
                "V": return "...-";
                "W": return ".--";
                "X": return "-..-";
                "Y": return "-.--";
                "Z": return "--..";
                default: return "";
            endcase
        endfunction

        // Tone time left between the ramps, floored at zero.
        function logic [LEN_W-1:0] steady_len(int unsigned units);
            int unsigned total;
            int unsigned ramps;
            total = units * int'(dot_unit);
            ramps = int'(rise_len) + int'(fall_len);
            return (total > ramps) ? LEN_W'(total - ramps) : '0;
        endfunction

        function void add_segment(logic [2:0] kind, int unsigned len, logic [1:0] ptt);
            mtk_out_t s;
            s.segment_kind   = kind;
            s.segment_length = LEN_W'(len);
            s.ptt_request    = ptt;
            s.last           = 1'b0;
            segments_due.push_back(s);
        endfunction

        // Predicts the segments of one accepted word; returns 1 when the
        // word is ignored by the block (command 3, tick with transmit off).
        function bit note_word(mtk_in_t w);
            string       pat;
            int unsigned n;
            int unsigned before_cnt;
            bit          ignored;
            mtk_out_t    tail;
            before_cnt = segments_due.size();
            ignored    = 1'b0;
            case (w.command)
                CMD_CHAR: begin
                    pat = morse_of(w.character);
                    if (pat.len() != 0) begin
                        hang_ticks = 0;
                        if (!tx_on) begin
                            tx_on = 1'b1;
                            add_segment(SEG_SILENCE, 3 * int'(dot_unit), PTT_ON);
                        end
                        n = (pat.len() > MAX_ELEMENTS) ? MAX_ELEMENTS : pat.len();
                        for (int i = 0; i < n; i++) begin
                            add_segment(SEG_RAMP_UP, rise_len, PTT_NONE);
                            add_segment(SEG_STEADY, steady_len((pat[i] == "-") ? 3 : 1),
                                        PTT_NONE);
                            add_segment(SEG_RAMP_DOWN, fall_len, PTT_NONE);
                            add_segment(SEG_SILENCE, dot_unit, PTT_NONE);
                        end
                        add_segment(SEG_SILENCE, 2 * int'(dot_unit), PTT_NONE);
                        after_silence = 1'b0;
                    end else begin
                        add_segment(SEG_SILENCE, (after_silence ? 7 : 4) * int'(dot_unit),
                                    PTT_NONE);
                        after_silence = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (tx_on) begin
                        if (hang_ticks < 255)
                            hang_ticks++;
                        if (hang_ticks > hang_lim) begin
                            add_segment(SEG_SILENCE, 0, PTT_OFF);
                            tx_on      = 1'b0;
                            hang_ticks = 0;
                            releases++;
                        end
                    end else begin
                        ignored = 1'b1;
                    end
                end
                CMD_END: add_segment(SEG_END, 0, PTT_NONE);
                default: ignored = 1'b1;
            endcase
            // The final segment of the word carries the last flag.
            if (segments_due.size() > before_cnt) begin
                tail      = segments_due.pop_back();
                tail.last = 1'b1;
                segments_due.push_back(tail);
            end
            return ignored;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        function void check_segment(mtk_out_t got);
            mtk_out_t want;
            segments_checked++;
            if (segments_due.size() == 0) begin
                note_failure($sformatf("segment with none due: kind %0d length %0d ptt %0d last %0d",
                             got.segment_kind, got.segment_length, got.ptt_request, got.last));
                return;
            end
            want = segments_due.pop_front();
            if (got.segment_kind !== want.segment_kind ||
                    got.segment_length !== want.segment_length ||
                    got.ptt_request !== want.ptt_request ||
                    got.last !== want.last)
                note_failure($sformatf({"segment %0d: expected kind %0d length %0d ptt %0d",
                             " last %0d, got kind %0d length %0d ptt %0d last %0d"},
                             segments_checked, want.segment_kind, want.segment_length,
                             want.ptt_request, want.last, got.segment_kind,
                             got.segment_length, got.ptt_request, got.last));
        endfunction

        function int unsigned pending();
            return segments_due.size();
        endfunction
    endclass

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    mtk_in_t            s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    mtk_out_t           m_data;

    keyer_scoreboard board = new();
    bit              steady_flow   = 1'b0;
    int unsigned     words_sent    = 0;
    int unsigned     settings_used = 0;
    int unsigned     cycle_count   = 0;

    morse_text_keyer_sequencer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Segment receiver: checks every accepted segment and stalls at random unless steady flow is set.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_segment(m_data);
        m_ready <= steady_flow || ($urandom_range(99) >= 30);
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d segments outstanding",
                     cycle_count, board.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Register write in a setup phase, an access phase and an idle phase; the
    // register takes the value at the access edge.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_register(idx, value);
        @(posedge aclk);
    endtask

    task automatic apply_setting(int unsigned dot, int unsigned rise, int unsigned fall,
                                 int unsigned hang);
        write_reg(REG_DOT_SPACE, dot);
        write_reg(REG_RISE, rise);
        write_reg(REG_FALL, fall);
        write_reg(REG_HANG, hang);
        settings_used++;
    endtask

    // Offers one word, with an occasional gap first, and waits until it is taken.
    task automatic send_word(logic [1:0] cmd, logic [7:0] ch);
        mtk_in_t w;
        w.command   = cmd;
        w.character = ch;
        if (!steady_flow && $urandom_range(99) < 30) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        void'(board.note_word(w));
        words_sent++;
    endtask

    // Holds the sender off until every segment is back and the block has settled.
    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] mapped_char();
        logic [7:0] c;
        string      pat;
        do begin
            c   = 8'($urandom_range(255));
            pat = board.morse_of(c);
        end while (pat.len() == 0);
        return c;
    endfunction

    function automatic logic [7:0] unmapped_char();
        logic [7:0] c;
        string      pat;
        if ($urandom_range(1) == 0)
            return " ";
        do begin
            c   = 8'($urandom_range(255));
            pat = board.morse_of(c);
        end while (pat.len() != 0);
        return c;
    endfunction

    // Mostly text made of words and spaces, with tick runs, end markers and noise.
    task automatic run_random(int unsigned target);
        int unsigned start_cnt;
        int unsigned pick;
        int unsigned n;
        start_cnt = words_sent;
        while (words_sent - start_cnt < target) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                n = $urandom_range(1, 5);
                repeat (n) send_word(CMD_CHAR, mapped_char());
                send_word(CMD_CHAR, unmapped_char());
            end else if (pick < 70) begin
                n = $urandom_range(1, (board.hang_lim < 18) ? board.hang_lim + 3 : 20);
                repeat (n) send_word(CMD_TICK, 8'($urandom_range(255)));
            end else if (pick < 78) begin
                send_word(CMD_END, 8'($urandom_range(255)));
            end else begin
                send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
            end
        end
        drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset timing, with a short hang limit.
        write_reg(REG_HANG, 1);
        send_word(CMD_CHAR, "E");
        send_word(CMD_CHAR, "T");
        send_word(CMD_CHAR, "0");
        send_word(CMD_CHAR, "?");
        send_word(CMD_CHAR, 8'hE1);
        send_word(CMD_CHAR, 8'hC5);
        send_word(CMD_CHAR, " ");
        send_word(CMD_CHAR, 8'h00);
        send_word(CMD_CHAR, 8'hFF);
        send_word(CMD_END, 8'h00);
        send_word(2'd3, "A");
        send_word(CMD_TICK, 8'h00);
        send_word(CMD_TICK, 8'hFF);
        send_word(CMD_TICK, 8'h00);
        send_word(CMD_CHAR, "@");
        send_word(CMD_CHAR, "[");
        send_word(CMD_END, 8'hFF);
        drain();

        // Random text under several timings, extremes included.
        apply_setting(3200, 240, 240, 15);
        run_random(40);
        apply_setting(1, 4095, 4095, 0);
        run_random(40);
        steady_flow = 1'b1;
        apply_setting(65535, 0, 0, 255);
        run_random(40);
        steady_flow = 1'b0;
        apply_setting(100, 50, 60, 2);
        run_random(40);
        apply_setting(0, 7, 4095, 4);
        run_random(40);
        apply_setting($urandom_range(1, 65535), $urandom_range(4095), $urandom_range(4095),
                      $urandom_range(20));
        run_random(40);

        $display("Run covered %0d words under %0d register settings plus the reset timing.",
                 words_sent, settings_used);
        $display("%0d segments checked, %0d transmit releases, %0d mismatches.",
                 board.segments_checked, board.releases, board.failures);
        if (board.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
